### src/wlf_pkg.sv
package wlf_pkg;

   localparam int MAX_POINTS_DEF = 32;
   localparam int DIV_BITS = 128;
   localparam int STEP_W = 8;

   localparam logic [1:0] FIT_OK = 2'd0;
   localparam logic [1:0] FIT_DEGENERATE = 2'd1;
   localparam logic [1:0] FIT_ZERO_SIGMA = 2'd2;
   localparam logic [1:0] FIT_DROPPED = 2'd3;

   localparam logic KIND_POINT = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic signed [15:0] x_value;
      logic signed [15:0] y_value;
      logic [15:0] y_error;
      logic final_point;
   } req_item_type;

   typedef struct packed {
      logic signed [15:0] x_value;
      logic signed [15:0] y_value;
      logic [15:0] y_error;
   } point_type;

   typedef struct packed {
      logic item_kind;
      logic [5:0] point_index;
      logic signed [31:0] fitted_y;
      logic signed [31:0] residual_value;
      logic signed [31:0] slope;
      logic [31:0] slope_error;
      logic signed [31:0] intercept;
      logic [31:0] intercept_error;
      logic [47:0] chi_square;
      logic [1:0] fit_status;
      logic last_result;
   } rsp_item_type;

   typedef struct packed {
      logic start;
      logic [STEP_W-1:0] steps;
   } div_ctl_type;

   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         sat_add64 = a[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
      end else begin
         sat_add64 = s;
      end
   endfunction

   function automatic logic [31:0] quot_sat(input logic [DIV_BITS-1:0] q, input logic neg);
      logic big;
      big = |q[DIV_BITS-1:32];
      if (!neg) begin
         quot_sat = (big || q[31]) ? 32'h7FFF_FFFF : q[31:0];
      end else begin
         quot_sat = (big || (q[31] && (|q[30:0]))) ? 32'h8000_0000 : (32'd0 - q[31:0]);
      end
   endfunction

endpackage

### src/wlf_div.sv
module wlf_div (
   input  logic clock,
   input  logic reset,
   input  wlf_pkg::div_ctl_type ctl,
   input  logic [wlf_pkg::DIV_BITS-1:0] dividend,
   input  logic [wlf_pkg::DIV_BITS-1:0] divisor,
   output logic done,
   output logic [wlf_pkg::DIV_BITS-1:0] quotient
);
   localparam int W = wlf_pkg::DIV_BITS;

   logic run_ff, run_in;
   logic done_ff, done_in;
   logic [wlf_pkg::STEP_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0] n_ff, n_in, r_ff, r_in, q_ff, q_in, d_ff, d_in;
   logic [W-1:0] r_shift;
   logic ge;

   always_comb begin
      r_shift = {r_ff[W-2:0], n_ff[W-1]};
      ge = (r_shift >= d_ff);
      run_in = run_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      n_in = n_ff;
      r_in = r_ff;
      q_in = q_ff;
      d_in = d_ff;
      if (ctl.start) begin
         run_in = 1'b1;
         cnt_in = ctl.steps;
         n_in = dividend;
         d_in = divisor;
         r_in = '0;
         q_in = '0;
      end else if (run_ff) begin
         r_in = ge ? (r_shift - d_ff) : r_shift;
         q_in = {q_ff[W-2:0], ge};
         n_in = {n_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 1) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      n_ff <= n_in;
      r_ff <= r_in;
      q_ff <= q_in;
      d_ff <= d_in;
   end

   assign done = done_ff;
   assign quotient = q_ff;

endmodule

### src/wlf_sqrt.sv
module wlf_sqrt (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [63:0] value,
   output logic done,
   output logic [31:0] root
);
   logic run_ff, run_in;
   logic done_ff, done_in;
   logic [63:0] v_ff, v_in, res_ff, res_in, bit_ff, bit_in;
   logic [63:0] trial;

   always_comb begin
      trial = res_ff + bit_ff;
      run_in = run_ff;
      done_in = 1'b0;
      v_in = v_ff;
      res_in = res_ff;
      bit_in = bit_ff;
      if (start) begin
         run_in = 1'b1;
         v_in = value;
         res_in = '0;
         bit_in = 64'd1 << 62;
      end else if (run_ff) begin
         if (v_ff >= trial) begin
            v_in = v_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
      end
      v_ff <= v_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[31:0];

endmodule

### src/weighted_line_fit_core.sv
// per point with nonzero y_error: 33-step weight division, then multiply-accumulate
// final point adds 64x64 products and, unless degenerate or zero sigma, four
// 128-step divisions, up to two 32-step roots and a 42-step division per stored point
// one item at a time through a single shared multiplier, divider and root unit
// results are strobed for one cycle; the receiver cannot stall
// synchronous reset clears count, sums, flags and sequencer; point store is not cleared
module weighted_line_fit_core #(
   parameter int MAX_POINTS = wlf_pkg::MAX_POINTS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  wlf_pkg::req_item_type req_item,
   output logic rsp_valid,
   output wlf_pkg::rsp_item_type rsp_item
);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int W = wlf_pkg::DIV_BITS;

   typedef enum logic [29:0] {
      ST_IDLE   = 30'b1 << 0,
      ST_PT     = 30'b1 << 1,
      ST_W_SQ   = 30'b1 << 2,
      ST_W_DIV  = 30'b1 << 3,
      ST_W_WAIT = 30'b1 << 4,
      ST_A0     = 30'b1 << 5,
      ST_A1     = 30'b1 << 6,
      ST_A2     = 30'b1 << 7,
      ST_A3     = 30'b1 << 8,
      ST_A4     = 30'b1 << 9,
      ST_A5     = 30'b1 << 10,
      ST_A6     = 30'b1 << 11,
      ST_P_MUL  = 30'b1 << 12,
      ST_P_ACC  = 30'b1 << 13,
      ST_P_FIX  = 30'b1 << 14,
      ST_P_ADD  = 30'b1 << 15,
      ST_D_CHK  = 30'b1 << 16,
      ST_Q_DIV  = 30'b1 << 17,
      ST_Q_WAIT = 30'b1 << 18,
      ST_R_DIV  = 30'b1 << 19,
      ST_R_WAIT = 30'b1 << 20,
      ST_R_SQW  = 30'b1 << 21,
      ST_L_RD   = 30'b1 << 22,
      ST_L_MX   = 30'b1 << 23,
      ST_L_FY   = 30'b1 << 24,
      ST_L_DF   = 30'b1 << 25,
      ST_L_DW   = 30'b1 << 26,
      ST_L_SQ   = 30'b1 << 27,
      ST_L_OUT  = 30'b1 << 28,
      ST_L_SUM  = 30'b1 << 29
   } state_type;

   state_type state_ff, state_in;
   wlf_pkg::req_item_type in_ff, in_in;
   logic [CW-1:0] cnt_ff, cnt_in, idx_ff, idx_in;
   logic [1:0] flags_ff, flags_in, st_ff, st_in;
   logic signed [63:0] sw_ff, sw_in, sx_ff, sx_in, sy_ff, sy_in;
   logic signed [63:0] sxx_ff, sxx_in, sxy_ff, sxy_in;
   logic [32:0] w_ff, w_in;
   logic signed [67:0] prod_ff, prod_in;
   logic signed [33:0] mul_a, mul_b;
   logic [2:0] pstep_ff, pstep_in;
   logic [1:0] part_ff, part_in;
   logic [W-1:0] u_ff, u_in, acc_ff, acc_in, d_ff, d_in;
   logic qneg_ff, qneg_in, rsel_ff, rsel_in;
   logic [31:0] m_ff, m_in, c_ff, c_in, dm_ff, dm_in, dc_ff, dc_in;
   logic [31:0] fy_ff, fy_in, res_ff, res_in;
   logic [47:0] chi_ff, chi_in;
   logic rsp_valid_ff, rsp_valid_in;
   wlf_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   wlf_pkg::point_type mem [MAX_POINTS];
   wlf_pkg::point_type rd_ff;

   logic signed [63:0] op_a, op_b;
   logic [63:0] mag_a, mag_b;
   logic [31:0] half_a, half_b;
   logic pneg, fit_ok;

   wlf_pkg::div_ctl_type div_ctl;
   logic [W-1:0] div_dividend, div_divisor, div_quot;
   logic div_done;
   logic sq_start, sq_done;
   logic [63:0] sq_value;
   logic [31:0] sq_root;

   logic [W-1:0] pp, shv;
   logic signed [39:0] fl;
   logic signed [40:0] fsum;
   logic signed [33:0] diff;
   logic signed [41:0] scaled;
   logic [41:0] smag;
   logic [48:0] chi_sum;

   wlf_div u_div (
      .clock(clock), .reset(reset), .ctl(div_ctl), .dividend(div_dividend),
      .divisor(div_divisor), .done(div_done), .quotient(div_quot)
   );

   wlf_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sq_start), .value(sq_value),
      .done(sq_done), .root(sq_root)
   );

   assign busy = (state_ff != ST_IDLE);
   assign fit_ok = (st_ff == wlf_pkg::FIT_OK) || (st_ff == wlf_pkg::FIT_DROPPED);

   // operand pairs of the wide products
   always_comb begin
      case (pstep_ff)
         3'd0: begin op_a = sw_ff; op_b = sxx_ff; end
         3'd1: begin op_a = sx_ff; op_b = sx_ff; end
         3'd2: begin op_a = sw_ff; op_b = sxy_ff; end
         3'd3: begin op_a = sx_ff; op_b = sy_ff; end
         3'd4: begin op_a = sy_ff; op_b = sxx_ff; end
         default: begin op_a = sx_ff; op_b = sxy_ff; end
      endcase
      mag_a = op_a[63] ? (64'd0 - op_a) : op_a;
      mag_b = op_b[63] ? (64'd0 - op_b) : op_b;
      half_a = part_ff[1] ? mag_a[63:32] : mag_a[31:0];
      half_b = part_ff[0] ? mag_b[63:32] : mag_b[31:0];
      pneg = op_a[63] ^ op_b[63];
   end

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_W_SQ: begin
            mul_a = {18'b0, in_ff.y_error};
            mul_b = {18'b0, in_ff.y_error};
         end
         ST_A0: begin
            mul_a = {{18{in_ff.x_value[15]}}, in_ff.x_value};
            mul_b = {1'b0, w_ff};
         end
         ST_A1: begin
            mul_a = {{18{in_ff.y_value[15]}}, in_ff.y_value};
            mul_b = {1'b0, w_ff};
         end
         ST_A2: begin
            mul_a = {{18{in_ff.x_value[15]}}, in_ff.x_value};
            mul_b = {{18{in_ff.x_value[15]}}, in_ff.x_value};
         end
         ST_A3, ST_A5: begin
            mul_a = prod_ff[33:0];
            mul_b = {1'b0, w_ff};
         end
         ST_A4: begin
            mul_a = {{18{in_ff.x_value[15]}}, in_ff.x_value};
            mul_b = {{18{in_ff.y_value[15]}}, in_ff.y_value};
         end
         ST_P_MUL: begin
            mul_a = {2'b0, half_a};
            mul_b = {2'b0, half_b};
         end
         ST_L_MX: begin
            mul_a = {{2{m_ff[31]}}, m_ff};
            mul_b = {{18{rd_ff.x_value[15]}}, rd_ff.x_value};
         end
         ST_L_SQ: begin
            mul_a = {{2{res_ff[31]}}, res_ff};
            mul_b = {{2{res_ff[31]}}, res_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_comb begin
      pp = {64'b0, prod_ff[63:0]};
      shv = (pstep_ff == 3'd4) ? {acc_ff[W-17:0], 16'b0} : {acc_ff[W-9:0], 8'b0};
      fl = prod_ff[47:8];
      fsum = {fl[39], fl} + {{9{c_ff[31]}}, c_ff};
      diff = {{2{fy_ff[31]}}, fy_ff} - {{10{rd_ff.y_value[15]}}, rd_ff.y_value, 8'b0};
      scaled = {diff, 8'b0};
      smag = scaled[41] ? (42'd0 - scaled) : scaled;
      chi_sum = {1'b0, chi_ff} + {1'b0, prod_ff[63:16]};
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      in_in = in_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      flags_in = flags_ff;
      st_in = st_ff;
      sw_in = sw_ff;
      sx_in = sx_ff;
      sy_in = sy_ff;
      sxx_in = sxx_ff;
      sxy_in = sxy_ff;
      w_in = w_ff;
      pstep_in = pstep_ff;
      part_in = part_ff;
      u_in = u_ff;
      acc_in = acc_ff;
      d_in = d_ff;
      qneg_in = qneg_ff;
      rsel_in = rsel_ff;
      m_in = m_ff;
      c_in = c_ff;
      dm_in = dm_ff;
      dc_in = dc_ff;
      fy_in = fy_ff;
      res_in = res_ff;
      chi_in = chi_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in = '0;
      div_ctl = '0;
      div_dividend = '0;
      div_divisor = d_ff;
      sq_start = 1'b0;
      sq_value = div_quot[63:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               in_in = req_item;
               state_in = ST_PT;
            end
         end
         ST_PT: begin
            if (cnt_ff < CW'(MAX_POINTS)) begin
               cnt_in = cnt_ff + 1'b1;
               if (in_ff.y_error == '0) begin
                  flags_in[0] = 1'b1;
               end
            end else begin
               flags_in[1] = 1'b1;
            end
            if (cnt_ff < CW'(MAX_POINTS) && in_ff.y_error != '0) begin
               state_in = ST_W_SQ;
            end else if (in_ff.final_point) begin
               pstep_in = '0;
               part_in = '0;
               u_in = '0;
               state_in = ST_P_MUL;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_W_SQ: state_in = ST_W_DIV;
         ST_W_DIV: begin
            div_ctl.start = 1'b1;
            div_ctl.steps = wlf_pkg::STEP_W'(33);
            div_dividend = {1'b1, {(W-1){1'b0}}};
            div_divisor = {{(W-32){1'b0}}, prod_ff[31:0]};
            state_in = ST_W_WAIT;
         end
         ST_W_WAIT: begin
            if (div_done) begin
               w_in = div_quot[32:0];
               state_in = ST_A0;
            end
         end
         ST_A0: begin
            sw_in = wlf_pkg::sat_add64(sw_ff, {31'b0, w_ff});
            state_in = ST_A1;
         end
         ST_A1: begin
            sx_in = wlf_pkg::sat_add64(sx_ff, prod_ff[63:0]);
            state_in = ST_A2;
         end
         ST_A2: begin
            sy_in = wlf_pkg::sat_add64(sy_ff, prod_ff[63:0]);
            state_in = ST_A3;
         end
         ST_A3: state_in = ST_A4;
         ST_A4: begin
            sxx_in = wlf_pkg::sat_add64(sxx_ff, prod_ff[63:0]);
            state_in = ST_A5;
         end
         ST_A5: state_in = ST_A6;
         ST_A6: begin
            sxy_in = wlf_pkg::sat_add64(sxy_ff, prod_ff[63:0]);
            if (in_ff.final_point) begin
               pstep_in = '0;
               part_in = '0;
               u_in = '0;
               state_in = ST_P_MUL;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_P_MUL: state_in = ST_P_ACC;
         ST_P_ACC: begin
            if (part_ff == 2'd3) begin
               u_in = u_ff + (pp << 64);
               state_in = ST_P_FIX;
            end else if (part_ff == 2'd0) begin
               u_in = u_ff + pp;
               state_in = ST_P_MUL;
            end else begin
               u_in = u_ff + (pp << 32);
               state_in = ST_P_MUL;
            end
            part_in = part_ff + 1'b1;
         end
         ST_P_FIX: begin
            if (pneg) begin
               u_in = '0 - u_ff;
            end
            state_in = ST_P_ADD;
         end
         ST_P_ADD: begin
            acc_in = pstep_ff[0] ? (acc_ff - u_ff) : u_ff;
            pstep_in = pstep_ff + 1'b1;
            part_in = '0;
            u_in = '0;
            if (!pstep_ff[0]) begin
               state_in = ST_P_MUL;
            end else if (pstep_ff == 3'd1) begin
               state_in = ST_D_CHK;
            end else begin
               state_in = ST_Q_DIV;
            end
         end
         ST_D_CHK: begin
            d_in = acc_ff;
            if (flags_ff[0]) begin
               st_in = wlf_pkg::FIT_ZERO_SIGMA;
            end else if (acc_ff[W-1] || acc_ff == '0) begin
               st_in = wlf_pkg::FIT_DEGENERATE;
            end else if (flags_ff[1]) begin
               st_in = wlf_pkg::FIT_DROPPED;
            end else begin
               st_in = wlf_pkg::FIT_OK;
            end
            if (!flags_ff[0] && !(acc_ff[W-1] || acc_ff == '0)) begin
               state_in = ST_P_MUL;
            end else begin
               m_in = '0;
               c_in = '0;
               dm_in = '0;
               dc_in = '0;
               idx_in = '0;
               state_in = (cnt_ff == '0) ? ST_L_SUM : ST_L_RD;
            end
         end
         ST_Q_DIV: begin
            qneg_in = shv[W-1];
            div_ctl.start = 1'b1;
            div_ctl.steps = wlf_pkg::STEP_W'(W);
            div_dividend = shv[W-1] ? ('0 - shv) : shv;
            state_in = ST_Q_WAIT;
         end
         ST_Q_WAIT: begin
            if (div_done) begin
               if (pstep_ff == 3'd4) begin
                  m_in = wlf_pkg::quot_sat(div_quot, qneg_ff);
                  state_in = ST_P_MUL;
               end else begin
                  c_in = wlf_pkg::quot_sat(div_quot, qneg_ff);
                  rsel_in = 1'b0;
                  state_in = ST_R_DIV;
               end
            end
         end
         ST_R_DIV: begin
            div_ctl.start = 1'b1;
            div_ctl.steps = wlf_pkg::STEP_W'(W);
            div_dividend = rsel_ff ? {16'b0, sxx_ff, 48'b0} : {sw_ff, 64'b0};
            state_in = ST_R_WAIT;
         end
         ST_R_WAIT: begin
            if (div_done) begin
               if (|div_quot[W-1:64]) begin
                  if (rsel_ff) begin
                     dc_in = 32'hFFFF_FFFF;
                     idx_in = '0;
                     state_in = (cnt_ff == '0) ? ST_L_SUM : ST_L_RD;
                  end else begin
                     dm_in = 32'hFFFF_FFFF;
                     rsel_in = 1'b1;
                     state_in = ST_R_DIV;
                  end
               end else begin
                  sq_start = 1'b1;
                  state_in = ST_R_SQW;
               end
            end
         end
         ST_R_SQW: begin
            if (sq_done) begin
               if (rsel_ff) begin
                  dc_in = sq_root;
                  idx_in = '0;
                  state_in = (cnt_ff == '0) ? ST_L_SUM : ST_L_RD;
               end else begin
                  dm_in = sq_root;
                  rsel_in = 1'b1;
                  state_in = ST_R_DIV;
               end
            end
         end
         ST_L_RD: begin
            if (fit_ok) begin
               state_in = ST_L_MX;
            end else begin
               fy_in = '0;
               res_in = '0;
               state_in = ST_L_OUT;
            end
         end
         ST_L_MX: state_in = ST_L_FY;
         ST_L_FY: begin
            if (fsum[40:31] == '0 || fsum[40:31] == '1) begin
               fy_in = fsum[31:0];
            end else begin
               fy_in = fsum[40] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            state_in = ST_L_DF;
         end
         ST_L_DF: begin
            qneg_in = scaled[41];
            div_ctl.start = 1'b1;
            div_ctl.steps = wlf_pkg::STEP_W'(42);
            div_dividend = {smag, {(W-42){1'b0}}};
            div_divisor = {{(W-16){1'b0}}, rd_ff.y_error};
            state_in = ST_L_DW;
         end
         ST_L_DW: begin
            if (div_done) begin
               res_in = wlf_pkg::quot_sat(div_quot, qneg_ff);
               state_in = ST_L_SQ;
            end
         end
         ST_L_SQ: state_in = ST_L_OUT;
         ST_L_OUT: begin
            if (fit_ok) begin
               chi_in = chi_sum[48] ? {48{1'b1}} : chi_sum[47:0];
            end
            rsp_valid_in = 1'b1;
            rsp_item_in.item_kind = wlf_pkg::KIND_POINT;
            rsp_item_in.point_index = 6'(idx_ff);
            rsp_item_in.fitted_y = fy_ff;
            rsp_item_in.residual_value = res_ff;
            rsp_item_in.fit_status = st_ff;
            idx_in = idx_ff + 1'b1;
            state_in = (idx_ff + 1'b1 == cnt_ff) ? ST_L_SUM : ST_L_RD;
         end
         ST_L_SUM: begin
            rsp_valid_in = 1'b1;
            rsp_item_in.item_kind = wlf_pkg::KIND_SUMMARY;
            rsp_item_in.point_index = 6'(cnt_ff);
            rsp_item_in.slope = m_ff;
            rsp_item_in.slope_error = dm_ff;
            rsp_item_in.intercept = c_ff;
            rsp_item_in.intercept_error = dc_ff;
            rsp_item_in.chi_square = chi_ff;
            rsp_item_in.fit_status = st_ff;
            rsp_item_in.last_result = 1'b1;
            cnt_in = '0;
            flags_in = '0;
            sw_in = '0;
            sx_in = '0;
            sy_in = '0;
            sxx_in = '0;
            sxy_in = '0;
            chi_in = '0;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         flags_ff <= '0;
         sw_ff <= '0;
         sx_ff <= '0;
         sy_ff <= '0;
         sxx_ff <= '0;
         sxy_ff <= '0;
         chi_ff <= '0;
         rsp_valid_ff <= 1'b0;
         st_ff <= wlf_pkg::FIT_OK;
         idx_ff <= '0;
         pstep_ff <= '0;
         part_ff <= '0;
         rsel_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         flags_ff <= flags_in;
         sw_ff <= sw_in;
         sx_ff <= sx_in;
         sy_ff <= sy_in;
         sxx_ff <= sxx_in;
         sxy_ff <= sxy_in;
         chi_ff <= chi_in;
         rsp_valid_ff <= rsp_valid_in;
         st_ff <= st_in;
         idx_ff <= idx_in;
         pstep_ff <= pstep_in;
         part_ff <= part_in;
         rsel_ff <= rsel_in;
      end
      in_ff <= in_in;
      w_ff <= w_in;
      prod_ff <= prod_in;
      u_ff <= u_in;
      acc_ff <= acc_in;
      d_ff <= d_in;
      qneg_ff <= qneg_in;
      m_ff <= m_in;
      c_ff <= c_in;
      dm_ff <= dm_in;
      dc_ff <= dc_in;
      fy_ff <= fy_in;
      res_ff <= res_in;
      rsp_item_ff <= rsp_item_in;
   end

   // point store
   always_ff @(posedge clock) begin
      if (state_ff == ST_PT && cnt_ff < CW'(MAX_POINTS)) begin
         mem[cnt_ff[AW-1:0]] <= {in_ff.x_value, in_ff.y_value, in_ff.y_error};
      end
      rd_ff <= mem[idx_ff[AW-1:0]];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_item_ff;

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("sequencer state not one-hot");
   a_cap: assert property (@(posedge clock) disable iff (reset) cnt_ff <= CW'(MAX_POINTS))
      else $error("point count above capacity");
   a_sum_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.last_result |-> cnt_ff == '0 && !busy)
      else $error("run state not cleared after summary item");
   a_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_item_ff.last_result |-> rsp_item_ff.point_index < 6'(cnt_ff))
      else $error("per-point item beyond stored points");
   a_take: assert property (@(posedge clock) disable iff (reset) start && !busy |=> busy)
      else $error("accepted item did not start work");

endmodule
